[hdl/dvfd_pkg.sv]
// Shared types, constants and the CRC byte update for the dual-version frame deframer.
package dvfd_pkg;

   localparam int BYTE_W   = 8;
   localparam int WORD_W   = 16;
   localparam int COUNT_W  = 17;
   localparam int KIND_W   = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [BYTE_W-1:0] SYNC_V1 = 8'h5A;
   localparam logic [BYTE_W-1:0] SYNC_V2 = 8'h5B;
   localparam logic [WORD_W-1:0] CRC_POLY = 16'h1021;

   localparam logic [WORD_W-1:0] CRC_INIT_RESET   = 16'hFFFF;
   localparam logic [WORD_W-1:0] MAX_LENGTH_RESET = 16'd517;

   localparam logic [CSR_IDX_W-1:0] CSR_CRC_INIT   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH = 1'b1;

   localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FAILED   = 2'd2;

   // Byte positions of the source, destination and command header bytes and of the first payload byte.
   localparam logic [COUNT_W-1:0] POS_SOURCE  = 17'd4;
   localparam logic [COUNT_W-1:0] POS_DEST    = 17'd5;
   localparam logic [COUNT_W-1:0] POS_COMMAND = 17'd6;
   localparam logic [COUNT_W-1:0] POS_PAYLOAD = 17'd7;

   localparam int RSP_DEPTH = 4;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HEADER,
      PH_DATA
   } phase_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] payload_byte;
      logic [WORD_W-1:0] byte_offset;
      logic              frame_version;
      logic [BYTE_W-1:0] source_id;
      logic [BYTE_W-1:0] dest_id;
      logic [BYTE_W-1:0] command;
      logic [WORD_W-1:0] payload_length;
      logic              last;
   } rsp_item_type;

   function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
      logic [WORD_W-1:0] x;
      x = crc ^ {data, 8'h00};
      for (int i = 0; i < BYTE_W; i++) begin
         if (x[WORD_W-1]) begin
            x = {x[WORD_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            x = {x[WORD_W-2:0], 1'b0};
         end
      end
      return x;
   endfunction

endpackage

[hdl/dual_version_frame_deframer_unit.sv]
// Top level of the dual-version frame deframer: sync hunt, header parse, checks, result queue.
//
// The block takes one received byte per cycle while the result queue has room, and updates
// the frame state in the same cycle; each byte yields zero, one or two results, which
// enter a four-entry result queue that feeds the output channel. A byte is taken whenever
// at least two queue entries are free, so with the output side always ready the input runs
// at one byte per cycle; the final byte of a frame with payload yields two results, which
// the queue absorbs. Results are registered in the queue before they appear on the output.
module dual_version_frame_deframer_unit
   import dvfd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // rx_byte
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // payload_byte, byte_offset, frame_version, source_id, dest_id, command, payload_length,
   // then zero fill
   output logic [71:0]          rsp_tdata,
   output logic [KIND_W-1:0]    rsp_tuser,   // kind
   output logic                 rsp_tlast,   // last
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata
);

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   logic [WORD_W-1:0]  crc_init_ff, max_length_ff;

   phase_type          phase_ff, phase_in;
   logic               frame_kind_ff, frame_kind_in;
   logic               first_sync_ff, first_sync_in;
   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [BYTE_W-1:0]  sum_ff, sum_in;
   logic [WORD_W-1:0]  crc_ff, crc_in;
   logic [WORD_W-1:0]  check_ff, check_in;
   logic [WORD_W-1:0]  length_ff, length_in;
   logic [BYTE_W-1:0]  source_ff, source_in;
   logic [BYTE_W-1:0]  dest_ff, dest_in;
   logic [BYTE_W-1:0]  command_ff, command_in;

   rsp_item_type       queue_ff [RSP_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;

   logic               accept;
   logic               pop;
   logic               push_a, push_b;
   rsp_item_type       res_a, res_b;
   rsp_item_type       head;
   logic [BYTE_W-1:0]  rx;

   assign rx         = req_tdata;
   assign req_tready = (fill_ff <= CNT_W'(RSP_DEPTH - 2));
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = (fill_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;

   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;
   assign rsp_tdata  = {7'b0, head.payload_length, head.command, head.dest_id, head.source_id,
                        head.frame_version, head.byte_offset, head.payload_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_init_ff   <= CRC_INIT_RESET;
         max_length_ff <= MAX_LENGTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CRC_INIT:   crc_init_ff   <= csr_wdata;
            CSR_MAX_LENGTH: max_length_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [COUNT_W-1:0] next_count;
      logic [BYTE_W-1:0]  next_sum;
      logic [WORD_W-1:0]  next_crc;
      logic               done;
      logic               ok;
      rsp_item_type       status;
      rsp_item_type       data_item;

      phase_in      = phase_ff;
      frame_kind_in = frame_kind_ff;
      first_sync_in = first_sync_ff;
      byte_count_in = byte_count_ff;
      sum_in        = sum_ff;
      crc_in        = crc_ff;
      check_in      = check_ff;
      length_in     = length_ff;
      source_in     = source_ff;
      dest_in       = dest_ff;
      command_in    = command_ff;
      push_a        = 1'b0;
      push_b        = 1'b0;
      next_count    = byte_count_ff + COUNT_W'(1);
      next_sum      = sum_ff + rx;
      next_crc      = crc_byte(crc_ff, rx);
      done          = 1'b0;
      ok            = 1'b0;
      res_a         = '0;
      res_b         = '0;
      status        = '0;
      data_item     = '0;

      if (accept) begin
         case (phase_ff)
            PH_HUNT: begin
               if (rx == SYNC_V1) begin
                  frame_kind_in = 1'b0;
                  first_sync_in = 1'b0;
                  byte_count_in = COUNT_W'(1);
                  phase_in      = PH_HEADER;
               end else if (rx == SYNC_V2) begin
                  if (first_sync_ff) begin
                     frame_kind_in = 1'b1;
                     first_sync_in = 1'b0;
                     byte_count_in = '0;
                     phase_in      = PH_HEADER;
                  end else begin
                     first_sync_in = 1'b1;
                  end
               end else begin
                  first_sync_in = 1'b0;
                  byte_count_in = '0;
                  phase_in      = PH_HUNT;
               end
            end
            PH_HEADER: begin
               case (byte_count_ff[1:0])
                  2'd0: check_in = {8'h00, rx};
                  2'd1: check_in = frame_kind_ff ? {rx, check_ff[7:0]} : {8'h00, rx};
                  2'd2: length_in = {8'h00, rx};
                  default: length_in = {rx, length_ff[7:0]};
               endcase
               byte_count_in = next_count;
               if (byte_count_ff[1:0] == 2'd3) begin
                  if (length_in <= max_length_ff) begin
                     sum_in   = '0;
                     crc_in   = crc_init_ff;
                     phase_in = PH_DATA;
                  end else begin
                     first_sync_in = 1'b0;
                     byte_count_in = '0;
                     phase_in      = PH_HUNT;
                  end
               end
            end
            PH_DATA: begin
               if (frame_kind_ff) begin
                  crc_in = next_crc;
               end else begin
                  sum_in = next_sum;
               end
               if (byte_count_ff == POS_SOURCE) begin
                  source_in = rx;
               end else if (byte_count_ff == POS_DEST) begin
                  dest_in = rx;
               end else if (byte_count_ff == POS_COMMAND) begin
                  command_in = rx;
               end
               byte_count_in = next_count;
               done = next_count >= ({1'b0, length_ff} + POS_PAYLOAD);
               ok   = frame_kind_ff ? ((~next_crc) == check_ff) : (next_sum == check_ff[7:0]);

               data_item.kind           = KIND_PAYLOAD;
               data_item.payload_byte   = rx;
               data_item.byte_offset    = byte_count_ff[WORD_W-1:0] - POS_PAYLOAD[WORD_W-1:0];
               data_item.frame_version  = frame_kind_ff;
               data_item.source_id      = source_in;
               data_item.dest_id        = dest_in;
               data_item.command        = command_in;
               data_item.payload_length = length_ff;
               data_item.last           = !done;

               status.kind           = ok ? KIND_ACCEPTED : KIND_FAILED;
               status.frame_version  = frame_kind_ff;
               status.source_id      = source_in;
               status.dest_id        = dest_in;
               status.command        = command_in;
               status.payload_length = length_ff;
               status.last           = 1'b1;

               if (byte_count_ff >= POS_PAYLOAD) begin
                  push_a = 1'b1;
                  res_a  = data_item;
                  push_b = done;
                  res_b  = status;
               end else begin
                  push_a = done;
                  res_a  = status;
               end
               if (done) begin
                  first_sync_in = 1'b0;
                  byte_count_in = '0;
                  phase_in      = PH_HUNT;
               end
            end
            default: begin
               first_sync_in = 1'b0;
               byte_count_in = '0;
               phase_in      = PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         frame_kind_ff <= 1'b0;
         first_sync_ff <= 1'b0;
         byte_count_ff <= '0;
         sum_ff        <= '0;
         crc_ff        <= CRC_INIT_RESET;
         check_ff      <= '0;
         length_ff     <= '0;
         source_ff     <= '0;
         dest_ff       <= '0;
         command_ff    <= '0;
      end else begin
         phase_ff      <= phase_in;
         frame_kind_ff <= frame_kind_in;
         first_sync_ff <= first_sync_in;
         byte_count_ff <= byte_count_in;
         sum_ff        <= sum_in;
         crc_ff        <= crc_in;
         check_ff      <= check_in;
         length_ff     <= length_in;
         source_ff     <= source_in;
         dest_ff       <= dest_in;
         command_ff    <= command_in;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_a) + PTR_W'(push_b);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      fill_in   = fill_ff + CNT_W'(push_a) + CNT_W'(push_b) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_a) begin
         queue_ff[wr_ptr_ff] <= res_a;
      end
      if (push_b) begin
         queue_ff[wr_ptr_ff + PTR_W'(1)] <= res_b;
      end
   end

endmodule

[bench/deframer_result_checker.sv]
// CRC helper for building frames and the result checker that predicts and compares deframer output.
package dvfd_bench_pkg;
   import dvfd_pkg::*;

   function automatic logic [WORD_W-1:0] crc_ccitt_next(input logic [WORD_W-1:0] acc,
                                                        input logic [BYTE_W-1:0] data);
      logic [WORD_W-1:0] r;
      logic              fb;
      r = acc;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
         fb = r[WORD_W-1] ^ data[i];
         r  = {r[WORD_W-2:0], 1'b0};
         if (fb) begin
            r = r ^ CRC_POLY;
         end
      end
      return r;
   endfunction

endpackage

module deframer_result_checker
   import dvfd_pkg::*;
   import dvfd_bench_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [71:0]          rsp_tdata,
   input  logic [KIND_W-1:0]    rsp_tuser,
   input  logic                 rsp_tlast,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata,
   output int                   fail_count,
   output int                   pending,
   output int                   payload_count,
   output int                   accepted_count,
   output int                   failed_count
);

   phase_type          frame_phase;
   logic               v2_frame;
   logic               sync_seen;
   logic [COUNT_W-1:0] position;
   logic [BYTE_W-1:0]  sum_check;
   logic [WORD_W-1:0]  crc_check;
   logic [WORD_W-1:0]  header_word;
   logic [WORD_W-1:0]  length_word;
   logic [BYTE_W-1:0]  source_byte;
   logic [BYTE_W-1:0]  dest_byte;
   logic [BYTE_W-1:0]  command_byte;
   logic [WORD_W-1:0]  crc_seed;
   logic [WORD_W-1:0]  length_limit;
   rsp_item_type       due_results[$];
   rsp_item_type       seen;
   rsp_item_type       oldest;

   task automatic restart_hunt();
      sync_seen   = 1'b0;
      position    = '0;
      frame_phase = PH_HUNT;
   endtask

   task automatic queue_result(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] value,
                               input logic [WORD_W-1:0] offset, input logic last);
      rsp_item_type r;
      r.kind           = kind;
      r.payload_byte   = value;
      r.byte_offset    = offset;
      r.frame_version  = v2_frame;
      r.source_id      = source_byte;
      r.dest_id        = dest_byte;
      r.command        = command_byte;
      r.payload_length = length_word;
      r.last           = last;
      due_results.push_back(r);
      if (kind == KIND_PAYLOAD) begin
         payload_count++;
      end else if (kind == KIND_ACCEPTED) begin
         accepted_count++;
      end else begin
         failed_count++;
      end
   endtask

   task automatic deframe_byte(input logic [BYTE_W-1:0] b);
      logic [COUNT_W-1:0] pos;
      logic               done;
      logic               good;
      case (frame_phase)
         PH_HUNT: begin
            if (b == SYNC_V1) begin
               v2_frame    = 1'b0;
               sync_seen   = 1'b0;
               position    = COUNT_W'(1);
               frame_phase = PH_HEADER;
            end else if (b == SYNC_V2) begin
               if (sync_seen) begin
                  v2_frame    = 1'b1;
                  sync_seen   = 1'b0;
                  position    = '0;
                  frame_phase = PH_HEADER;
               end else begin
                  sync_seen = 1'b1;
               end
            end else begin
               restart_hunt();
            end
         end
         PH_HEADER: begin
            case (position)
               0: header_word = {8'h00, b};
               1: header_word = v2_frame ? {b, header_word[7:0]} : {8'h00, b};
               2: length_word = {8'h00, b};
               default: length_word = {b, length_word[7:0]};
            endcase
            position = position + 1'b1;
            if (position >= POS_SOURCE) begin
               if (length_word <= length_limit) begin
                  sum_check   = '0;
                  crc_check   = crc_seed;
                  frame_phase = PH_DATA;
               end else begin
                  restart_hunt();
               end
            end
         end
         PH_DATA: begin
            pos = position;
            if (v2_frame) begin
               crc_check = crc_ccitt_next(crc_check, b);
            end else begin
               sum_check = sum_check + b;
            end
            if (pos == POS_SOURCE) begin
               source_byte = b;
            end else if (pos == POS_DEST) begin
               dest_byte = b;
            end else if (pos == POS_COMMAND) begin
               command_byte = b;
            end
            position = position + 1'b1;
            done = ({1'b0, position} >= ({2'b00, length_word} + {1'b0, POS_PAYLOAD}));
            if (pos >= POS_PAYLOAD) begin
               queue_result(KIND_PAYLOAD, b, 16'(pos - POS_PAYLOAD), !done);
            end
            if (done) begin
               good = v2_frame ? (~crc_check == header_word) : (sum_check == header_word[7:0]);
               queue_result(good ? KIND_ACCEPTED : KIND_FAILED, '0, '0, 1'b1);
               restart_hunt();
            end
         end
         default: restart_hunt();
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $error("Field %s mismatch: expected %0h, got %0h.", name, want_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         frame_phase  = PH_HUNT;
         v2_frame     = 1'b0;
         sync_seen    = 1'b0;
         position     = '0;
         sum_check    = '0;
         crc_seed     = CRC_INIT_RESET;
         crc_check    = CRC_INIT_RESET;
         header_word  = '0;
         length_word  = '0;
         source_byte  = '0;
         dest_byte    = '0;
         command_byte = '0;
         length_limit = MAX_LENGTH_RESET;
         due_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CRC_INIT: crc_seed = csr_wdata;
               CSR_MAX_LENGTH: length_limit = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            deframe_byte(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.kind           = rsp_tuser;
            seen.payload_byte   = rsp_tdata[7:0];
            seen.byte_offset    = rsp_tdata[23:8];
            seen.frame_version  = rsp_tdata[24];
            seen.source_id      = rsp_tdata[32:25];
            seen.dest_id        = rsp_tdata[40:33];
            seen.command        = rsp_tdata[48:41];
            seen.payload_length = rsp_tdata[64:49];
            seen.last           = rsp_tlast;
            if (due_results.size() == 0) begin
               $error("Result transfer with nothing expected, kind %0d.", rsp_tuser);
               fail_count++;
            end else begin
               oldest = due_results.pop_front();
               check_field("kind", 32'(oldest.kind), 32'(seen.kind));
               check_field("payload_byte", 32'(oldest.payload_byte), 32'(seen.payload_byte));
               check_field("byte_offset", 32'(oldest.byte_offset), 32'(seen.byte_offset));
               check_field("frame_version", 32'(oldest.frame_version),
                           32'(seen.frame_version));
               check_field("source_id", 32'(oldest.source_id), 32'(seen.source_id));
               check_field("dest_id", 32'(oldest.dest_id), 32'(seen.dest_id));
               check_field("command", 32'(oldest.command), 32'(seen.command));
               check_field("payload_length", 32'(oldest.payload_length),
                           32'(seen.payload_length));
               check_field("last", 32'(oldest.last), 32'(seen.last));
            end
         end
      end
      pending = due_results.size();
   end

endmodule

[bench/dual_version_frame_deframer_unit_tb.sv]
// Testbench top for the dual-version frame deframer: clock, reset, byte stimulus and verdict.
module dual_version_frame_deframer_unit_tb;
   import dvfd_pkg::*;
   import dvfd_bench_pkg::*;

   localparam int RESET_CYCLES   = 9;
   localparam int HOLD_CYCLES    = 60;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_BYTES    = 115;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [7:0]           req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [71:0]          rsp_tdata;
   logic [KIND_W-1:0]    rsp_tuser;
   logic                 rsp_tlast;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]    csr_wdata;

   int          fail_count;
   int          pending;
   int          payload_count;
   int          accepted_count;
   int          failed_count;
   int          bytes_sent;
   int          settings_used;
   int          idle_cycles;
   logic        calm;
   logic        stall_long;
   logic [15:0] crc_seed_now;
   logic [15:0] length_cap_now;

   dual_version_frame_deframer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   deframer_result_checker results_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending        (pending),
      .payload_count  (payload_count),
      .accepted_count (accepted_count),
      .failed_count   (failed_count)
   );

   always #1 clock = ~clock;

   function automatic int pick_gap();
      int roll;
      if (calm) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         return 0;
      end else if (roll < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   initial begin
      int idle;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_long) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            stall_long = 1'b0;
         end else begin
            idle = pick_gap();
            if (idle > 0) begin
               rsp_tready <= 1'b0;
               repeat (idle) @(negedge clock);
            end
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] value);
      int idle;
      idle = pick_gap();
      @(negedge clock);
      if (idle > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // A negative limit sends the whole frame; otherwise only its first limit bytes.
   task automatic send_frame(input logic v2, input logic [15:0] len, input logic [7:0] src,
                             input logic [7:0] dst, input logic [7:0] cmd, input logic corrupt,
                             input int limit);
      logic [7:0]  body[$];
      logic [7:0]  sum;
      logic [15:0] crc;
      logic [15:0] check;
      logic [3:0]  flip;
      int          count;
      body.push_back(src);
      body.push_back(dst);
      body.push_back(cmd);
      repeat (len) body.push_back(8'($urandom));
      sum = '0;
      crc = crc_seed_now;
      foreach (body[i]) begin
         sum = sum + body[i];
         crc = crc_ccitt_next(crc, body[i]);
      end
      check = v2 ? ~crc : {8'h00, sum};
      if (corrupt) begin
         flip = 4'($urandom_range(0, v2 ? 15 : 7));
         check[flip] = ~check[flip];
      end
      body.push_front(len[15:8]);
      body.push_front(len[7:0]);
      if (v2) begin
         body.push_front(check[15:8]);
         body.push_front(check[7:0]);
         body.push_front(SYNC_V2);
         body.push_front(SYNC_V2);
      end else begin
         body.push_front(check[7:0]);
         body.push_front(SYNC_V1);
      end
      count = (limit < 0 || limit > body.size()) ? body.size() : limit;
      for (int i = 0; i < count; i++) begin
         send_byte(body[i]);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] index, input logic [WORD_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [15:0] seed, input logic [15:0] cap);
      csr_write(CSR_CRC_INIT, seed);
      csr_write(CSR_MAX_LENGTH, cap);
      crc_seed_now   = seed;
      length_cap_now = cap;
      settings_used++;
   endtask

   // Mostly complete frames with random content; the rest is sync noise, cut-off frames
   // and frames whose length field exceeds the current limit.
   task automatic run_traffic(input int budget);
      int stop;
      int roll;
      int len;
      stop = bytes_sent + budget;
      while (bytes_sent < stop) begin
         calm = ($urandom_range(0, 4) == 0);
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            len = (roll < 60) ? $urandom_range(0, 12) : $urandom_range(13, 48);
            if (len > length_cap_now) begin
               len = length_cap_now;
            end
            send_frame(1'($urandom_range(0, 1)), 16'(len), 8'($urandom), 8'($urandom),
                       8'($urandom), $urandom_range(0, 3) == 0, -1);
         end else if (roll < 80) begin
            repeat ($urandom_range(1, 4)) begin
               send_byte(($urandom_range(0, 3) == 0) ? SYNC_V2 : 8'($urandom));
            end
         end else if (roll < 90 || length_cap_now == 16'hFFFF) begin
            len = $urandom_range(4, 20);
            if (len > length_cap_now) begin
               len = length_cap_now;
            end
            send_frame(1'($urandom_range(0, 1)), 16'(len), 8'($urandom), 8'($urandom),
                       8'($urandom), 1'b0, $urandom_range(1, 8));
         end else begin
            len = $urandom_range(int'(length_cap_now) + 1, 65535);
            send_frame(1'($urandom_range(0, 1)), 16'(len), 8'($urandom), 8'($urandom),
                       8'($urandom), 1'b0, $urandom_range(4, 9));
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_we         = 1'b0;
      csr_index      = CSR_CRC_INIT;
      csr_wdata      = '0;
      calm           = 1'b0;
      stall_long     = 1'b0;
      bytes_sent     = 0;
      settings_used  = 1;
      crc_seed_now   = CRC_INIT_RESET;
      length_cap_now = MAX_LENGTH_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A lone first sync byte, then one followed directly by a version one start.
      send_byte(SYNC_V2);
      send_byte(8'h00);
      send_byte(SYNC_V2);
      send_frame(1'b0, 16'd1, 8'hFF, 8'h00, 8'h80, 1'b0, -1);
      // Three sync bytes in a row, the third taken as the checksum low byte; zero length.
      send_byte(SYNC_V2);
      send_byte(SYNC_V2);
      send_byte(SYNC_V2);
      send_byte(8'hC3);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h7F);
      // Largest length field, above the limit, so the frame is dropped.
      send_frame(1'b0, 16'hFFFF, 8'h01, 8'h02, 8'h03, 1'b0, 6);
      wait_idle();

      // Hold the result side off while a long frame is offered, so the input stalls.
      stall_long = 1'b1;
      calm       = 1'b1;
      send_frame(1'b1, 16'd24, 8'h5A, 8'hA5, 8'h3C, 1'b0, -1);
      calm = 1'b0;
      run_traffic(PHASE_BYTES);
      wait_idle();

      apply_setting(16'h0000, 16'h0000);
      run_traffic(PHASE_BYTES);
      wait_idle();

      apply_setting(16'h1D0F, 16'hFFFF);
      run_traffic(PHASE_BYTES);
      wait_idle();

      apply_setting(16'($urandom), 16'($urandom_range(1, 24)));
      run_traffic(PHASE_BYTES);
      wait_idle();

      $display("Sent %0d bytes under %0d register settings, with sync noise, cut-off and",
               bytes_sent, settings_used);
      $display("overlong frames; checked %0d payload bytes, %0d good and %0d bad frames.",
               payload_count, accepted_count, failed_count);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
